[sv/mips_pkg.sv]
package mips_pkg;

	localparam int DATA_WORDS_DEF = 1024;
	localparam logic [31:0] TEXT_START = 32'h0040_0000;
	localparam logic [4:0] REG_V0 = 5'd2;
	localparam logic [4:0] REG_RA = 5'd31;
	localparam logic [31:0] EXIT_CODE = 32'd10;

	localparam logic [5:0] OP_SPECIAL = 6'h00;
	localparam logic [5:0] OP_REGIMM = 6'h01;
	localparam logic [5:0] OP_J = 6'h02;
	localparam logic [5:0] OP_JAL = 6'h03;
	localparam logic [5:0] OP_BEQ = 6'h04;
	localparam logic [5:0] OP_BNE = 6'h05;
	localparam logic [5:0] OP_BLEZ = 6'h06;
	localparam logic [5:0] OP_BGTZ = 6'h07;
	localparam logic [5:0] OP_ADDI = 6'h08;
	localparam logic [5:0] OP_ADDIU = 6'h09;
	localparam logic [5:0] OP_SLTI = 6'h0A;
	localparam logic [5:0] OP_SLTIU = 6'h0B;
	localparam logic [5:0] OP_ANDI = 6'h0C;
	localparam logic [5:0] OP_ORI = 6'h0D;
	localparam logic [5:0] OP_XORI = 6'h0E;
	localparam logic [5:0] OP_LUI = 6'h0F;
	localparam logic [5:0] OP_LB = 6'h20;
	localparam logic [5:0] OP_LH = 6'h21;
	localparam logic [5:0] OP_LW = 6'h23;
	localparam logic [5:0] OP_LBU = 6'h24;
	localparam logic [5:0] OP_LHU = 6'h25;
	localparam logic [5:0] OP_SB = 6'h28;
	localparam logic [5:0] OP_SH = 6'h29;
	localparam logic [5:0] OP_SW = 6'h2B;

	localparam logic [5:0] FN_SLL = 6'h00;
	localparam logic [5:0] FN_SRL = 6'h02;
	localparam logic [5:0] FN_SRA = 6'h03;
	localparam logic [5:0] FN_SLLV = 6'h04;
	localparam logic [5:0] FN_SRLV = 6'h06;
	localparam logic [5:0] FN_SRAV = 6'h07;
	localparam logic [5:0] FN_JR = 6'h08;
	localparam logic [5:0] FN_JALR = 6'h09;
	localparam logic [5:0] FN_SYSCALL = 6'h0C;
	localparam logic [5:0] FN_MFHI = 6'h10;
	localparam logic [5:0] FN_MTHI = 6'h11;
	localparam logic [5:0] FN_MFLO = 6'h12;
	localparam logic [5:0] FN_MTLO = 6'h13;
	localparam logic [5:0] FN_MULT = 6'h18;
	localparam logic [5:0] FN_MULTU = 6'h19;
	localparam logic [5:0] FN_DIV = 6'h1A;
	localparam logic [5:0] FN_DIVU = 6'h1B;
	localparam logic [5:0] FN_ADD = 6'h20;
	localparam logic [5:0] FN_ADDU = 6'h21;
	localparam logic [5:0] FN_SUB = 6'h22;
	localparam logic [5:0] FN_SUBU = 6'h23;
	localparam logic [5:0] FN_AND = 6'h24;
	localparam logic [5:0] FN_OR = 6'h25;
	localparam logic [5:0] FN_XOR = 6'h26;
	localparam logic [5:0] FN_NOR = 6'h27;
	localparam logic [5:0] FN_SLT = 6'h2A;
	localparam logic [5:0] FN_SLTU = 6'h2B;

	localparam logic [4:0] RT_BLTZ = 5'h00;
	localparam logic [4:0] RT_BGEZ = 5'h01;
	localparam logic [4:0] RT_BLTZAL = 5'h10;
	localparam logic [4:0] RT_BGEZAL = 5'h11;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RDA,
		ST_RDB,
		ST_EXEC,
		ST_MEM,
		ST_MUL,
		ST_DIV,
		ST_DIVFIN,
		ST_WB,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [31:0] next_pc;
		logic halted;
		logic reg_written;
		logic [4:0] reg_index;
		logic [31:0] reg_value;
	} result_t;

	typedef struct packed {
		logic req_type;
		logic [31:0] instruction;
		logic [9:0] mem_index;
		logic [31:0] mem_word;
	} request_t;

	typedef struct packed {
		logic start;
		logic is_signed;
		logic is_div;
	} md_ctrl_t;

	typedef struct packed {
		logic done;
		logic zero_div;
	} md_stat_t;

endpackage

[sv/mips_if.sv]
interface mips_req_if import mips_pkg::*; ();
	logic valid;
	logic ready;
	request_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface mips_res_if import mips_pkg::*; ();
	logic valid;
	logic ready;
	result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[sv/mips_ram.sv]
module mips_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[sv/mips_muldiv.sv]
module mips_muldiv import mips_pkg::*; (
	input logic clk,
	input logic arst_n,
	input md_ctrl_t ctrl,
	input logic [31:0] a,
	input logic [31:0] b,
	output md_stat_t stat,
	output logic [31:0] hi,
	output logic [31:0] lo
);
	logic [31:0] ma_q, mb_q, quo_q, rem_q;
	logic na_q, nb_q, div_q, busy_q, done_q;
	logic [5:0] cnt_q;
	logic [1:0] mcnt_q;
	logic [63:0] prod_q;
	logic [33:0] rtry;
	logic [32:0] rsh;
	logic [15:0] ph;
	logic [47:0] pp;
	logic [63:0] psum;

	assign rsh = {rem_q, quo_q[31]};
	assign rtry = {1'b0, rsh} - {2'b00, mb_q};
	assign ph = mcnt_q[0] ? mb_q[31:16] : mb_q[15:0];
	assign pp = ma_q * ph;
	assign psum = prod_q + (mcnt_q[0] ? {pp, 16'd0} : {16'd0, pp});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
			mcnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
				mcnt_q <= '0;
			end else if (busy_q) begin
				if (div_q) begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd31) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end else begin
					mcnt_q <= mcnt_q + 2'd1;
					if (mcnt_q == 2'd1) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			na_q <= ctrl.is_signed & a[31];
			nb_q <= ctrl.is_signed & b[31];
			ma_q <= (ctrl.is_signed & a[31]) ? 32'd0 - a : a;
			mb_q <= (ctrl.is_signed & b[31]) ? 32'd0 - b : b;
			quo_q <= (ctrl.is_signed & a[31]) ? 32'd0 - a : a;
			rem_q <= '0;
			prod_q <= '0;
			div_q <= ctrl.is_div;
		end else if (busy_q) begin
			if (div_q) begin
				if (!rtry[33]) begin
					rem_q <= rtry[31:0];
					quo_q <= {quo_q[30:0], 1'b1};
				end else begin
					rem_q <= rsh[31:0];
					quo_q <= {quo_q[30:0], 1'b0};
				end
			end else begin
				prod_q <= psum;
			end
		end
	end

	logic [63:0] sprod;
	assign sprod = (na_q ^ nb_q) ? 64'd0 - prod_q : prod_q;

	always_comb begin
		if (div_q) begin
			lo = (na_q ^ nb_q) ? 32'd0 - quo_q : quo_q;
			hi = na_q ? 32'd0 - rem_q : rem_q;
		end else begin
			lo = sprod[31:0];
			hi = sprod[63:32];
		end
	end

	assign stat.done = done_q;
	assign stat.zero_div = (mb_q == 32'd0);
endmodule

[sv/mips32_instruction_executor.sv]
// MIPS32 integer executor, one instruction or memory preload per transfer.
// Channels: req (sink) carries req_type, instruction, mem_index, mem_word;
// res (source) carries next_pc, halted, reg_written, reg_index, reg_value.
// One item is in flight at a time; a new request waits until the output
// register is free or being drained.
// Steps: a preload writes the data RAM when accepted; ALU, branch and jump
// do two register file reads through the single read port of the register
// RAM, execute and write back; loads and stores add a data RAM read, merge
// and write; mult/multu sum two 32x16 partial products; div/divu produce
// one quotient bit per cycle.
// Reset: pc = 0x00400000, running, hi = lo = 0, registers read as zero
// through per-register valid bits; data memory is undefined until written.
// A stalled receiver holds the result; a new request is accepted only once
// the output register is free or being drained.
// A halted block answers execute items with its unchanged state.
module mips32_instruction_executor import mips_pkg::*; #(
	parameter int DATA_WORDS = DATA_WORDS_DEF
) (
	input logic clk,
	input logic arst_n,
	mips_req_if.sink req,
	mips_res_if.source res
);
	localparam int AW = $clog2(DATA_WORDS);

	state_t state_q, state_d;
	logic [31:0] ins_q, pc_q, a_q, b_q, hi_q, lo_q, addr_q;
	logic run_q, rvalid_q;
	result_t res_q;
	logic [31:0] wval_q;
	logic wen_q;
	logic [4:0] widx_q;
	logic [31:0] npc_q;

	logic [5:0] op, fn;
	logic [4:0] rs, rt, rd, sa;
	logic [15:0] imm;
	logic [31:0] simm, pc4;
	assign op = ins_q[31:26];
	assign rs = ins_q[25:21];
	assign rt = ins_q[20:16];
	assign rd = ins_q[15:11];
	assign sa = ins_q[10:6];
	assign fn = ins_q[5:0];
	assign imm = ins_q[15:0];
	assign simm = {{16{imm[15]}}, imm};
	assign pc4 = pc_q + 32'd4;

	// register file
	logic rf_we;
	logic [4:0] rf_waddr, rf_raddr;
	logic [31:0] rf_wdata, rf_rdata, rf_val;
	mips_ram #(.WIDTH(32), .DEPTH(32)) u_rf (
		.clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
		.raddr(rf_raddr), .rdata(rf_rdata)
	);
	logic [31:0] rvld_q;
	logic rd_ok_q;
	assign rf_val = rd_ok_q ? rf_rdata : 32'd0;

	// data memory
	logic dm_we;
	logic [AW-1:0] dm_waddr, dm_raddr;
	logic [31:0] dm_wdata, dm_rdata;
	mips_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_dm (
		.clk(clk), .we(dm_we), .waddr(dm_waddr), .wdata(dm_wdata),
		.raddr(dm_raddr), .rdata(dm_rdata)
	);

	md_ctrl_t md_ctrl;
	md_stat_t md_stat;
	logic [31:0] md_hi, md_lo;
	mips_muldiv u_md (
		.clk(clk), .arst_n(arst_n), .ctrl(md_ctrl), .a(a_q), .b(b_q),
		.stat(md_stat), .hi(md_hi), .lo(md_lo)
	);

	logic accept, out_free;
	assign out_free = !rvalid_q || res.ready;
	assign req.ready = (state_q == ST_IDLE) && out_free;
	assign accept = req.valid && req.ready;
	assign res.valid = rvalid_q;
	assign res.data = res_q;

	// execute stage combinational result
	logic ex_wen;
	logic [4:0] ex_widx;
	logic [31:0] ex_wval, ex_npc;
	logic ex_mem, ex_mul, ex_div, ex_halt, ex_sethi, ex_setlo;
	logic [31:0] ex_addr;
	logic [4:0] shamt;
	assign ex_addr = a_q + simm;

	always_comb begin
		ex_wen = 1'b0;
		ex_widx = rd;
		ex_wval = '0;
		ex_npc = pc4;
		ex_mem = 1'b0;
		ex_mul = 1'b0;
		ex_div = 1'b0;
		ex_halt = 1'b0;
		ex_sethi = 1'b0;
		ex_setlo = 1'b0;
		shamt = (fn[2]) ? a_q[4:0] : sa;
		case (op)
			OP_SPECIAL: begin
				case (fn)
					FN_SLL, FN_SLLV: begin ex_wen = 1'b1; ex_wval = b_q << shamt; end
					FN_SRL, FN_SRLV: begin ex_wen = 1'b1; ex_wval = b_q >> shamt; end
					FN_SRA, FN_SRAV: begin
						ex_wen = 1'b1;
						ex_wval = 32'($signed(b_q) >>> shamt);
					end
					FN_JR: ex_npc = a_q;
					FN_JALR: begin ex_npc = a_q; ex_wen = 1'b1; ex_wval = pc4; end
					FN_SYSCALL: ex_halt = (b_q == EXIT_CODE);
					FN_MFHI: begin ex_wen = 1'b1; ex_wval = hi_q; end
					FN_MTHI: ex_sethi = 1'b1;
					FN_MFLO: begin ex_wen = 1'b1; ex_wval = lo_q; end
					FN_MTLO: ex_setlo = 1'b1;
					FN_MULT, FN_MULTU: ex_mul = 1'b1;
					FN_DIV, FN_DIVU: ex_div = 1'b1;
					FN_ADD, FN_ADDU: begin ex_wen = 1'b1; ex_wval = a_q + b_q; end
					FN_SUB, FN_SUBU: begin ex_wen = 1'b1; ex_wval = a_q - b_q; end
					FN_AND: begin ex_wen = 1'b1; ex_wval = a_q & b_q; end
					FN_OR: begin ex_wen = 1'b1; ex_wval = a_q | b_q; end
					FN_XOR: begin ex_wen = 1'b1; ex_wval = a_q ^ b_q; end
					FN_NOR: begin ex_wen = 1'b1; ex_wval = ~(a_q | b_q); end
					FN_SLT: begin
						ex_wen = 1'b1;
						ex_wval = {31'd0, $signed(a_q) < $signed(b_q)};
					end
					FN_SLTU: begin ex_wen = 1'b1; ex_wval = {31'd0, a_q < b_q}; end
					default: ;
				endcase
			end
			OP_REGIMM: begin
				if ((rt == RT_BLTZ || rt == RT_BLTZAL) && a_q[31]) begin
					ex_npc = pc4 + {simm[29:0], 2'b00};
				end
				if ((rt == RT_BGEZ || rt == RT_BGEZAL) && !a_q[31]) begin
					ex_npc = pc4 + {simm[29:0], 2'b00};
				end
				if (rt == RT_BLTZAL || rt == RT_BGEZAL) begin
					ex_wen = 1'b1;
					ex_widx = REG_RA;
					ex_wval = pc4;
				end
			end
			OP_J: ex_npc = {pc4[31:28], ins_q[25:0], 2'b00};
			OP_JAL: begin
				ex_npc = {pc4[31:28], ins_q[25:0], 2'b00};
				ex_wen = 1'b1;
				ex_widx = REG_RA;
				ex_wval = pc4;
			end
			OP_BEQ: if (a_q == b_q) ex_npc = pc4 + {simm[29:0], 2'b00};
			OP_BNE: if (a_q != b_q) ex_npc = pc4 + {simm[29:0], 2'b00};
			OP_BLEZ: if (a_q == 32'd0 || a_q[31]) ex_npc = pc4 + {simm[29:0], 2'b00};
			OP_BGTZ: if (a_q != 32'd0 && !a_q[31]) ex_npc = pc4 + {simm[29:0], 2'b00};
			OP_ADDI, OP_ADDIU: begin ex_wen = 1'b1; ex_widx = rt; ex_wval = a_q + simm; end
			OP_SLTI: begin
				ex_wen = 1'b1; ex_widx = rt;
				ex_wval = {31'd0, $signed(a_q) < $signed(simm)};
			end
			OP_SLTIU: begin ex_wen = 1'b1; ex_widx = rt; ex_wval = {31'd0, a_q < simm}; end
			OP_ANDI: begin ex_wen = 1'b1; ex_widx = rt; ex_wval = a_q & {16'd0, imm}; end
			OP_ORI: begin ex_wen = 1'b1; ex_widx = rt; ex_wval = a_q | {16'd0, imm}; end
			OP_XORI: begin ex_wen = 1'b1; ex_widx = rt; ex_wval = a_q ^ {16'd0, imm}; end
			OP_LUI: begin ex_wen = 1'b1; ex_widx = rt; ex_wval = {imm, 16'd0}; end
			OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU, OP_SB, OP_SH, OP_SW: ex_mem = 1'b1;
			default: ;
		endcase
	end

	// memory stage merge
	logic [4:0] bsh, hsh;
	logic [31:0] mem_ld, mem_st, bsw, hsw;
	logic mem_ldop;
	assign bsh = {addr_q[1:0], 3'b000};
	assign hsh = {addr_q[1], 4'b0000};
	assign bsw = dm_rdata >> bsh;
	assign hsw = dm_rdata >> hsh;
	assign mem_ldop = !op[3];
	always_comb begin
		mem_ld = dm_rdata;
		mem_st = b_q;
		case (op)
			OP_LB: mem_ld = {{24{bsw[7]}}, bsw[7:0]};
			OP_LH: mem_ld = {{16{hsw[15]}}, hsw[15:0]};
			OP_LBU: mem_ld = {24'd0, bsw[7:0]};
			OP_LHU: mem_ld = {16'd0, hsw[15:0]};
			OP_SB: mem_st = (dm_rdata & ~(32'hFF << bsh)) | ({24'd0, b_q[7:0]} << bsh);
			OP_SH: mem_st = (dm_rdata & ~(32'hFFFF << hsh)) | ({16'd0, b_q[15:0]} << hsh);
			default: ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		rf_raddr = rs;
		md_ctrl = '0;
		dm_raddr = ex_addr[AW+1:2];
		dm_we = 1'b0;
		dm_waddr = addr_q[AW+1:2];
		dm_wdata = mem_st;
		case (state_q)
			ST_IDLE: begin
				dm_waddr = AW'(req.data.mem_index);
				dm_wdata = req.data.mem_word;
				if (accept) begin
					if (req.data.req_type) begin
						dm_we = 1'b1;
					end else if (run_q) begin
						state_d = ST_RDA;
					end
				end
				rf_raddr = req.data.instruction[25:21];
			end
			ST_RDA: begin
				rf_raddr = (op == OP_SPECIAL && fn == FN_SYSCALL) ? REG_V0 : rt;
				state_d = ST_RDB;
			end
			ST_RDB: state_d = ST_EXEC;
			ST_EXEC: begin
				if (ex_mem) begin
					state_d = ST_MEM;
				end else if (ex_mul) begin
					md_ctrl.start = 1'b1;
					md_ctrl.is_signed = !fn[0];
					state_d = ST_MUL;
				end else if (ex_div) begin
					md_ctrl.start = 1'b1;
					md_ctrl.is_signed = !fn[0];
					md_ctrl.is_div = 1'b1;
					state_d = ST_DIV;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_MEM: begin
				dm_we = !mem_ldop;
				state_d = ST_OUT;
			end
			ST_MUL, ST_DIV: if (md_stat.done) state_d = ST_OUT;
			ST_OUT: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		rf_we = 1'b0;
		rf_waddr = widx_q;
		rf_wdata = wval_q;
		if (state_q == ST_OUT && out_free && wen_q) begin
			rf_we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= TEXT_START;
			run_q <= 1'b1;
			hi_q <= '0;
			lo_q <= '0;
			rvld_q <= '0;
			rd_ok_q <= 1'b0;
			rvalid_q <= 1'b0;
			wen_q <= 1'b0;
		end else begin
			if (accept && (req.data.req_type || !run_q)) begin
				rvalid_q <= 1'b1;
			end else if (state_q == ST_OUT && out_free) begin
				rvalid_q <= 1'b1;
			end else if (rvalid_q && res.ready) begin
				rvalid_q <= 1'b0;
			end
			rd_ok_q <= rvld_q[rf_raddr] && (rf_raddr != 5'd0);
			case (state_q)
				ST_EXEC: begin
					wen_q <= ex_wen && (ex_widx != 5'd0);
					if (ex_halt) run_q <= 1'b0;
					if (ex_sethi) hi_q <= a_q;
					if (ex_setlo) lo_q <= a_q;
				end
				ST_MEM: wen_q <= mem_ldop && (rt != 5'd0);
				ST_MUL, ST_DIV: begin
					if (md_stat.done && !(state_q == ST_DIV && md_stat.zero_div)) begin
						hi_q <= md_hi;
						lo_q <= md_lo;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						pc_q <= npc_q;
						if (wen_q) rvld_q[widx_q] <= 1'b1;
						wen_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ins_q <= req.data.instruction;
			res_q.next_pc <= pc_q;
			res_q.halted <= !run_q;
			res_q.reg_written <= 1'b0;
			res_q.reg_index <= '0;
			res_q.reg_value <= '0;
		end
		if (state_q == ST_RDA) a_q <= rf_val;
		if (state_q == ST_RDB) b_q <= rf_val;
		if (state_q == ST_EXEC) begin
			widx_q <= ex_widx;
			wval_q <= ex_wval;
			npc_q <= ex_npc;
			addr_q <= ex_addr;
		end
		if (state_q == ST_MEM) begin
			widx_q <= rt;
			wval_q <= mem_ld;
		end
		if (state_q == ST_OUT && out_free) begin
			res_q.next_pc <= npc_q;
			res_q.halted <= !run_q;
			res_q.reg_written <= wen_q;
			res_q.reg_index <= wen_q ? widx_q : 5'd0;
			res_q.reg_value <= wen_q ? wval_q : 32'd0;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.ready |=> res.valid)
		else $error("result dropped under stall");
	assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> state_q == ST_IDLE)
		else $error("request taken while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		rf_we |-> rf_waddr != 5'd0)
		else $error("register zero written");
	assert property (@(posedge clk) disable iff (!arst_n)
		!run_q |=> !run_q)
		else $error("halt released");
endmodule

[tb/mips32_instruction_executor_test.sv]
`timescale 1ns / 100ps

module mips32_instruction_executor_test;
	import mips_pkg::*;

	class exec_scoreboard;
		logic [31:0] gpr [32];
		logic [31:0] hi;
		logic [31:0] lo;
		logic [31:0] pc;
		bit running;
		logic [31:0] dmem [DATA_WORDS_DEF];
		result_t cur;
		result_t pending [$];
		int errors;
		int checked;

		function new();
			foreach (gpr[i]) gpr[i] = '0;
			hi = '0;
			lo = '0;
			pc = TEXT_START;
			running = 1'b1;
			errors = 0;
			checked = 0;
		endfunction

		function void put_reg(logic [4:0] idx, logic [31:0] v);
			if (idx == 5'd0) return;
			gpr[idx] = v;
			cur.reg_written = 1'b1;
			cur.reg_index = idx;
			cur.reg_value = v;
		endfunction

		function void execute(logic [31:0] ins);
			logic [31:0] pc4, npc, a, b, simm, zimm, btgt, jtgt, addr, w, ma, mb, q, r;
			logic [5:0] op, fn;
			logic [4:0] rs, rt, rd, sa;
			logic [9:0] slot;
			int bsh, hsh;
			logic [63:0] p;
			pc4 = pc + 32'd4;
			npc = pc4;
			op = ins[31:26];
			rs = ins[25:21];
			rt = ins[20:16];
			rd = ins[15:11];
			sa = ins[10:6];
			fn = ins[5:0];
			zimm = {16'h0, ins[15:0]};
			simm = {{16{ins[15]}}, ins[15:0]};
			a = gpr[rs];
			b = gpr[rt];
			btgt = pc4 + {simm[29:0], 2'b00};
			jtgt = {pc4[31:28], ins[25:0], 2'b00};
			addr = a + simm;
			slot = addr[11:2];
			w = dmem[slot];
			bsh = addr[1:0] * 8;
			hsh = addr[1] * 16;
			case (op)
				OP_SPECIAL: begin
					case (fn)
						FN_SLL: put_reg(rd, b << sa);
						FN_SRL: put_reg(rd, b >> sa);
						FN_SRA: put_reg(rd, $signed(b) >>> sa);
						FN_SLLV: put_reg(rd, b << a[4:0]);
						FN_SRLV: put_reg(rd, b >> a[4:0]);
						FN_SRAV: put_reg(rd, $signed(b) >>> a[4:0]);
						FN_JR: npc = a;
						FN_JALR: begin
							npc = a;
							put_reg(rd, pc4);
						end
						FN_SYSCALL: if (gpr[REG_V0] == EXIT_CODE) running = 1'b0;
						FN_MFHI: put_reg(rd, hi);
						FN_MTHI: hi = a;
						FN_MFLO: put_reg(rd, lo);
						FN_MTLO: lo = a;
						FN_MULT: begin
							p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
							{hi, lo} = p;
						end
						FN_MULTU: begin
							p = {32'h0, a} * {32'h0, b};
							{hi, lo} = p;
						end
						FN_DIV: if (b != 0) begin
							ma = a[31] ? -a : a;
							mb = b[31] ? -b : b;
							q = ma / mb;
							r = ma % mb;
							lo = (a[31] != b[31]) ? -q : q;
							hi = a[31] ? -r : r;
						end
						FN_DIVU: if (b != 0) begin
							lo = a / b;
							hi = a % b;
						end
						FN_ADD, FN_ADDU: put_reg(rd, a + b);
						FN_SUB, FN_SUBU: put_reg(rd, a - b);
						FN_AND: put_reg(rd, a & b);
						FN_OR: put_reg(rd, a | b);
						FN_XOR: put_reg(rd, a ^ b);
						FN_NOR: put_reg(rd, ~(a | b));
						FN_SLT: put_reg(rd, {31'h0, $signed(a) < $signed(b)});
						FN_SLTU: put_reg(rd, {31'h0, a < b});
						default: ;
					endcase
				end
				OP_REGIMM: begin
					if ((rt == RT_BLTZ || rt == RT_BLTZAL) && a[31]) npc = btgt;
					if ((rt == RT_BGEZ || rt == RT_BGEZAL) && !a[31]) npc = btgt;
					if (rt == RT_BLTZAL || rt == RT_BGEZAL) put_reg(REG_RA, pc4);
				end
				OP_J: npc = jtgt;
				OP_JAL: begin
					npc = jtgt;
					put_reg(REG_RA, pc4);
				end
				OP_BEQ: if (a == b) npc = btgt;
				OP_BNE: if (a != b) npc = btgt;
				OP_BLEZ: if (a == 0 || a[31]) npc = btgt;
				OP_BGTZ: if (a != 0 && !a[31]) npc = btgt;
				OP_ADDI, OP_ADDIU: put_reg(rt, a + simm);
				OP_SLTI: put_reg(rt, {31'h0, $signed(a) < $signed(simm)});
				OP_SLTIU: put_reg(rt, {31'h0, a < simm});
				OP_ANDI: put_reg(rt, a & zimm);
				OP_ORI: put_reg(rt, a | zimm);
				OP_XORI: put_reg(rt, a ^ zimm);
				OP_LUI: put_reg(rt, {ins[15:0], 16'h0});
				OP_LB: put_reg(rt, {{24{w[bsh + 7]}}, w[bsh +: 8]});
				OP_LH: put_reg(rt, {{16{w[hsh + 15]}}, w[hsh +: 16]});
				OP_LW: put_reg(rt, w);
				OP_LBU: put_reg(rt, {24'h0, w[bsh +: 8]});
				OP_LHU: put_reg(rt, {16'h0, w[hsh +: 16]});
				OP_SB: begin
					w[bsh +: 8] = b[7:0];
					dmem[slot] = w;
				end
				OP_SH: begin
					w[hsh +: 16] = b[15:0];
					dmem[slot] = w;
				end
				OP_SW: dmem[slot] = b;
				default: ;
			endcase
			pc = npc;
		endfunction

		function void note(request_t q);
			cur = '0;
			if (q.req_type) dmem[q.mem_index] = q.mem_word;
			else if (running) execute(q.instruction);
			cur.next_pc = pc;
			cur.halted = !running;
			pending.push_back(cur);
		endfunction

		function void check(result_t got);
			result_t e;
			checked++;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.next_pc !== e.next_pc) begin
				$display("%0t: next_pc expected %h actual %h", $time, e.next_pc, got.next_pc);
				errors++;
			end
			if (got.halted !== e.halted) begin
				$display("%0t: halted expected %b actual %b", $time, e.halted, got.halted);
				errors++;
			end
			if (got.reg_written !== e.reg_written) begin
				$display("%0t: reg_written expected %b actual %b", $time, e.reg_written,
					got.reg_written);
				errors++;
			end
			if (got.reg_index !== e.reg_index) begin
				$display("%0t: reg_index expected %0d actual %0d", $time, e.reg_index,
					got.reg_index);
				errors++;
			end
			if (got.reg_value !== e.reg_value) begin
				$display("%0t: reg_value expected %h actual %h", $time, e.reg_value,
					got.reg_value);
				errors++;
			end
		endfunction
	endclass

	localparam int CYCLE_LIMIT = 400000;
	localparam int PRELOAD_WORDS = 64;

	logic clk;
	logic arst_n;
	mips_req_if req_if ();
	mips_res_if res_if ();
	exec_scoreboard book;
	int sent_count;
	int cycle_count;
	bit quiet;
	bit holdoff_done;

	mips32_instruction_executor u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.res(res_if)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("status: fail");
			$finish;
		end
	end

	function automatic logic [31:0] rtype(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
			logic [4:0] sa, logic [5:0] fn);
		return {OP_SPECIAL, rs, rt, rd, sa, fn};
	endfunction

	function automatic logic [31:0] itype(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
			logic [15:0] imm);
		return {op, rs, rt, imm};
	endfunction

	function automatic logic [31:0] random_instruction();
		logic [5:0] fns [27] = '{FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV, FN_JR,
			FN_JALR, FN_SYSCALL, FN_MFHI, FN_MTHI, FN_MFLO, FN_MTLO, FN_MULT, FN_MULTU,
			FN_DIV, FN_DIVU, FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_AND, FN_OR, FN_XOR,
			FN_NOR, FN_SLT, FN_SLTU};
		logic [5:0] ops [23] = '{OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ, OP_ADDI,
			OP_ADDIU, OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI, OP_XORI, OP_LUI, OP_LB, OP_LH,
			OP_LW, OP_LBU, OP_LHU, OP_SB, OP_SH, OP_SW, OP_REGIMM};
		logic [4:0] rts [5] = '{RT_BLTZ, RT_BGEZ, RT_BLTZAL, RT_BGEZAL, 5'h05};
		logic [31:0] ins;
		int pick;
		ins = $urandom;
		pick = $urandom_range(99);
		if (pick < 45)
			ins[5:0] = fns[$urandom_range(26)];
		if (pick < 45)
			ins[31:26] = OP_SPECIAL;
		else if (pick < 92)
			ins[31:26] = ops[$urandom_range(22)];
		if (ins[31:26] == OP_REGIMM && pick < 92)
			ins[20:16] = rts[$urandom_range(4)];
		if (ins[31:26] inside {OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU, OP_SB, OP_SH, OP_SW}) begin
			ins[25:21] = 5'd0;
			ins[15:0] = {8'h00, ins[7:0]};
		end
		if (ins[31:26] == OP_SPECIAL && ins[5:0] == FN_SYSCALL && book.gpr[REG_V0] == EXIT_CODE)
			ins[5:0] = FN_SLL;
		return ins;
	endfunction

	task automatic send(request_t r);
		int gap;
		req_if.valid <= 1'b1;
		req_if.data <= r;
		@(posedge clk);
		while (!req_if.ready) @(posedge clk);
		book.note(r);
		sent_count++;
		if (!quiet && $urandom_range(99) < 32) begin
			gap = $urandom_range(1, 6);
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic run_instruction(logic [31:0] ins);
		request_t r;
		r = '0;
		r.instruction = ins;
		r.mem_index = 10'($urandom);
		r.mem_word = $urandom;
		send(r);
	endtask

	task automatic preload(logic [9:0] idx, logic [31:0] word);
		request_t r;
		r.req_type = 1'b1;
		r.instruction = $urandom;
		r.mem_index = idx;
		r.mem_word = word;
		send(r);
	endtask

	always @(posedge clk) begin
		int hold_left;
		if (arst_n) begin
			if (res_if.valid && res_if.ready) begin
				book.check(res_if.data);
				if (book.checked == 400 && !holdoff_done) begin
					hold_left = 300;
					holdoff_done = 1'b1;
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= quiet || ($urandom_range(99) >= 32);
			end
		end
	end

	initial begin
		book = new();
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.data = '0;
		res_if.ready = 1'b0;
		sent_count = 0;
		cycle_count = 0;
		quiet = 1'b0;
		holdoff_done = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < PRELOAD_WORDS; i++)
			preload(10'(i), (i % 7 == 0) ? 32'hFFFF_FFFF : $urandom);
		preload(10'h3FF, 32'h8000_0000);
		preload(10'h000, 32'h0000_0000);

		run_instruction(itype(OP_LUI, 5'd0, 5'd1, 16'h8000));
		run_instruction(itype(OP_ADDIU, 5'd0, 5'd3, 16'hFFFF));
		run_instruction(rtype(5'd1, 5'd3, 5'd4, 5'd0, FN_ADD));
		run_instruction(rtype(5'd1, 5'd4, 5'd5, 5'd0, FN_SUB));
		run_instruction(itype(OP_ADDI, 5'd5, 5'd6, 16'h7FFF));
		run_instruction(rtype(5'd1, 5'd3, 5'd0, 5'd0, FN_DIV));
		run_instruction(rtype(5'd0, 5'd0, 5'd7, 5'd0, FN_MFHI));
		run_instruction(rtype(5'd0, 5'd0, 5'd8, 5'd0, FN_MFLO));
		run_instruction(rtype(5'd3, 5'd0, 5'd0, 5'd0, FN_DIVU));
		run_instruction(rtype(5'd0, 5'd0, 5'd8, 5'd0, FN_MFLO));
		run_instruction(rtype(5'd1, 5'd3, 5'd0, 5'd0, FN_MULT));
		run_instruction(rtype(5'd0, 5'd0, 5'd9, 5'd0, FN_MFHI));
		run_instruction(rtype(5'd3, 5'd3, 5'd0, 5'd0, FN_MULTU));
		run_instruction(rtype(5'd0, 5'd0, 5'd0, 5'd0, FN_MFHI));
		run_instruction({OP_JAL, 26'h3FF_FFFF});
		run_instruction(rtype(5'd31, 5'd0, 5'd10, 5'd0, FN_JALR));
		run_instruction(itype(OP_REGIMM, 5'd1, RT_BLTZAL, 16'h8000));
		run_instruction(itype(OP_REGIMM, 5'd1, RT_BGEZAL, 16'h7FFF));
		run_instruction(itype(OP_REGIMM, 5'd0, 5'h1F, 16'h0004));
		run_instruction(32'hFFFF_FFFF);
		run_instruction(itype(OP_SB, 5'd3, 5'd1, 16'h0004));
		run_instruction(itype(OP_SH, 5'd0, 5'd3, 16'h0002));
		run_instruction(itype(OP_LB, 5'd0, 5'd11, 16'h0003));
		run_instruction(itype(OP_LHU, 5'd0, 5'd12, 16'h0002));
		run_instruction(rtype(5'd0, 5'd0, 5'd0, 5'd0, FN_SYSCALL));

		for (int i = 0; i < 600; i++) begin
			quiet = (i >= 300 && i < 400);
			if ($urandom_range(19) == 0)
				preload(10'($urandom), $urandom);
			else
				run_instruction(random_instruction());
		end
		quiet = 1'b0;

		run_instruction(itype(OP_ADDIU, 5'd0, REG_V0, 16'd10));
		run_instruction(rtype(5'd0, 5'd0, 5'd0, 5'd0, FN_SYSCALL));
		run_instruction(itype(OP_ADDIU, 5'd0, 5'd5, 16'd1));
		preload(10'd5, 32'h1234_5678);
		run_instruction({OP_J, 26'h0});
		req_if.valid <= 1'b0;

		while (book.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);

		$display("covered %0d transfers: memory preload, ALU, shifts, branches, jumps,", sent_count);
		$display("loads/stores, mult/div corner cases, halt; %0d results checked", book.checked);
		if (book.errors == 0 && book.pending.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
